@@ hdl/umpq_pkg.sv @@
package umpq_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int ENTRY_W = KEY_W + VALUE_W;
   localparam int FILL_W  = 5;

   // request kinds
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                      op;
      logic signed [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [KEY_W-1:0]   out_key;
      logic signed [VALUE_W-1:0] out_value;
      logic [FILL_W-1:0]         fill;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_SHIFT,
      STATE_FINISH
   } state_type;

endpackage

@@ hdl/umpq_mem.sv @@
module umpq_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [umpq_pkg::ENTRY_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [umpq_pkg::ENTRY_W-1:0] rd_data
);

   logic [umpq_pkg::ENTRY_W-1:0] mem_ff [DEPTH];
   logic [umpq_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/umpq_ctrl.sv @@
module umpq_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   // request side
   input  logic                         req_valid,
   output logic                         req_ready,
   input  umpq_pkg::req_type            req_data,
   // result side
   output logic                         res_valid,
   input  logic                         res_ready,
   output umpq_pkg::rsp_type            res_data,
   // memory port
   output logic                         mem_wr_en,
   output logic [AW-1:0]                mem_wr_addr,
   output logic [umpq_pkg::ENTRY_W-1:0] mem_wr_data,
   output logic                         mem_rd_en,
   output logic [AW-1:0]                mem_rd_addr,
   input  logic [umpq_pkg::ENTRY_W-1:0] mem_rd_data
);

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   umpq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [CW-1:0]       best_idx_ff, best_idx_in;
   logic signed [umpq_pkg::KEY_W-1:0]   best_key_ff, best_key_in;
   logic signed [umpq_pkg::VALUE_W-1:0] best_val_ff, best_val_in;
   umpq_pkg::rsp_type   res_ff, res_in;

   logic signed [umpq_pkg::KEY_W-1:0]   rd_key;
   logic signed [umpq_pkg::VALUE_W-1:0] rd_val;
   logic          accept;
   logic          take;
   logic          scan_last;
   logic [CW-1:0] wr_nx;
   logic [CW-1:0] rd_nx;
   logic          shift_more;

   assign rd_key = mem_rd_data[umpq_pkg::ENTRY_W-1:umpq_pkg::VALUE_W];
   assign rd_val = mem_rd_data[umpq_pkg::VALUE_W-1:0];

   assign req_ready = (state_ff == umpq_pkg::STATE_IDLE);
   assign accept    = req_valid && req_ready;
   assign res_valid = (state_ff == umpq_pkg::STATE_FINISH);
   assign res_data  = res_ff;

   // earliest entry wins a tie: replace only on strictly greater key
   assign take      = (idx_ff == '0) || (rd_key > best_key_ff);
   assign scan_last = (idx_ff == count_ff - ONE_C);
   assign wr_nx     = pend_ff ? idx_ff + ONE_C : idx_ff;
   assign rd_nx     = wr_nx + ONE_C;
   assign shift_more = (rd_nx < count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         umpq_pkg::STATE_IDLE: begin
            if (accept) begin
               if (req_data.op == umpq_pkg::OP_REMOVE && count_ff != '0) begin
                  state_in = umpq_pkg::STATE_SCAN;
               end else begin
                  state_in = umpq_pkg::STATE_FINISH;
               end
            end
         end
         umpq_pkg::STATE_SCAN: begin
            if (scan_last) begin
               state_in = umpq_pkg::STATE_SHIFT;
            end
         end
         umpq_pkg::STATE_SHIFT: begin
            if (!shift_more) begin
               state_in = umpq_pkg::STATE_FINISH;
            end
         end
         umpq_pkg::STATE_FINISH: begin
            if (res_ready) begin
               state_in = umpq_pkg::STATE_IDLE;
            end
         end
         default: state_in = umpq_pkg::STATE_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      best_idx_in = best_idx_ff;
      best_key_in = best_key_ff;
      best_val_in = best_val_ff;
      res_in      = res_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = {req_data.key, req_data.value};
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_nx[AW-1:0];
      unique case (state_ff)
         umpq_pkg::STATE_IDLE: begin
            if (accept) begin
               res_in.out_key   = '0;
               res_in.out_value = '0;
               if (req_data.op == umpq_pkg::OP_INSERT) begin
                  if (count_ff == DEPTH_C) begin
                     res_in.status = umpq_pkg::STATUS_FULL;
                     res_in.fill   = umpq_pkg::FILL_W'(count_ff);
                  end else begin
                     // append at the tail
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = count_ff[AW-1:0];
                     count_in      = count_ff + ONE_C;
                     res_in.status = umpq_pkg::STATUS_DONE;
                     res_in.fill   = umpq_pkg::FILL_W'(count_ff + ONE_C);
                  end
               end else if (count_ff == '0) begin
                  res_in.status = umpq_pkg::STATUS_EMPTY;
                  res_in.fill   = umpq_pkg::FILL_W'(count_ff);
               end else begin
                  // start the scan at the oldest entry
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  idx_in      = '0;
               end
            end
         end
         umpq_pkg::STATE_SCAN: begin
            if (take) begin
               best_idx_in = idx_ff;
               best_key_in = rd_key;
               best_val_in = rd_val;
            end
            if (scan_last) begin
               idx_in  = take ? idx_ff : best_idx_ff;
               pend_in = 1'b0;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[AW-1:0] + AW'(1);
               idx_in      = idx_ff + ONE_C;
            end
         end
         umpq_pkg::STATE_SHIFT: begin
            // move entry idx+1 down into idx, one per cycle
            mem_wr_en   = pend_ff;
            mem_wr_addr = idx_ff[AW-1:0];
            mem_wr_data = mem_rd_data;
            idx_in      = wr_nx;
            mem_rd_en   = shift_more;
            pend_in     = shift_more;
            if (!shift_more) begin
               count_in         = count_ff - ONE_C;
               res_in.status    = umpq_pkg::STATUS_DONE;
               res_in.out_key   = best_key_ff;
               res_in.out_value = best_val_ff;
               res_in.fill      = umpq_pkg::FILL_W'(count_ff - ONE_C);
            end
         end
         umpq_pkg::STATE_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= umpq_pkg::STATE_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      res_ff      <= res_in;
   end

endmodule

@@ hdl/unsorted_max_priority_queue.sv @@
// Bounded max-priority queue of signed 32-bit key/value pairs, DEPTH entries,
// kept in insertion order in one single-port-write, registered-read memory.
// Each request transfer yields exactly one result transfer with a status:
// done, insert refused (full), or remove on empty. Requests are handled one
// at a time. An insert, or any refused request, goes straight from idle to
// the finish state, where its result is offered. A remove runs a scan and a
// shift: the memory read port visits every stored key once to find the largest
// (earliest pair on a tie), then walks the later pairs down one slot each to
// close the gap. The result sits in an output register, so a new request is
// taken while the previous result waits on rsp_stall. No clearing pass after
// reset: a slot is only read after it has been written.
module unsorted_max_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  umpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output umpq_pkg::rsp_type rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                         req_ready;
   logic                         res_valid;
   logic                         res_ready;
   umpq_pkg::rsp_type            res_data;
   logic                         mem_wr_en;
   logic [AW-1:0]                mem_wr_addr;
   logic [umpq_pkg::ENTRY_W-1:0] mem_wr_data;
   logic                         mem_rd_en;
   logic [AW-1:0]                mem_rd_addr;
   logic [umpq_pkg::ENTRY_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   umpq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign req_stall = !req_ready;

   // output register is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   umpq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   umpq_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // load a finished result, or drop the held one once transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload unless a new result loads
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/umpq_checker.sv @@
module umpq_checker #(
   parameter int DEPTH = 16
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input umpq_pkg::rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // one request in flight: busy right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // refused requests carry no pair
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != umpq_pkg::STATUS_DONE
      |-> rsp_data.out_key == '0 && rsp_data.out_value == '0)
      else $error("refused result carries data");

   // fill never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && DEPTH < 32 |-> rsp_data.fill <= umpq_pkg::FILL_W'(DEPTH))
      else $error("fill above capacity");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind unsorted_max_priority_queue umpq_checker #(.DEPTH(DEPTH)) u_umpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ tb/unsorted_max_priority_queue_test.sv @@
`timescale 1ns / 100ps

module unsorted_max_priority_queue_test;

   localparam int DEPTH        = 16;
   localparam int CYCLE_LIMIT  = 500000;
   // generous margin over the longest remove, which is on a full queue
   localparam int SETTLE_TICKS = 60;
   localparam int HOLD_TICKS   = 400;

   // Shadow copy of the queue. Each accepted request is applied here in
   // transfer order, and the result it must produce waits in pending_results
   // until the matching result transfer arrives.
   class pq_mirror;
      logic signed [umpq_pkg::KEY_W-1:0]   keys [DEPTH];
      logic signed [umpq_pkg::VALUE_W-1:0] values [DEPTH];
      int unsigned                         count = 0;
      umpq_pkg::rsp_type                   pending_results [$];
      int unsigned                         mismatches = 0;

      function int unsigned outstanding();
         return pending_results.size();
      endfunction

      function void take_request(umpq_pkg::req_type r);
         umpq_pkg::rsp_type res;
         int best;
         res = '0;
         res.status = umpq_pkg::STATUS_DONE;
         if (r.op == umpq_pkg::OP_INSERT) begin
            if (count >= DEPTH) begin
               res.status = umpq_pkg::STATUS_FULL;
            end else begin
               keys[count]   = r.key;
               values[count] = r.value;
               count++;
            end
         end else if (count == 0) begin
            res.status = umpq_pkg::STATUS_EMPTY;
         end else begin
            // strict compare keeps the earliest pair on a tie
            best = 0;
            for (int i = 1; i < count; i++)
               if (keys[i] > keys[best])
                  best = i;
            res.out_key   = keys[best];
            res.out_value = values[best];
            // close the gap, keep insertion order
            for (int i = best; i + 1 < count; i++) begin
               keys[i]   = keys[i + 1];
               values[i] = values[i + 1];
            end
            count--;
         end
         res.fill = umpq_pkg::FILL_W'(count);
         pending_results.push_back(res);
      endfunction

      function void note_mismatch(string what, umpq_pkg::rsp_type want,
                                  umpq_pkg::rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display({"%0t: %s: expected status %0d key %0d value %0d fill %0d,",
                      " got status %0d key %0d value %0d fill %0d"},
                     $realtime, what,
                     want.status, want.out_key, want.out_value, want.fill,
                     got.status, got.out_key, got.out_value, got.fill);
      endfunction

      function void check_result(umpq_pkg::rsp_type got);
         umpq_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            note_mismatch("result with no request waiting", '0, got);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.out_key !== want.out_key ||
             got.out_value !== want.out_value || got.fill !== want.fill)
            note_mismatch("result mismatch", want, got);
      endfunction
   endclass

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_stall;
   umpq_pkg::req_type req_data   = '0;
   logic              rsp_valid;
   logic              rsp_stall  = 1'b0;
   umpq_pkg::rsp_type rsp_data;

   pq_mirror mirror = new();

   // idle rates in percent per cycle; the main sequence changes them by phase
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // long receiver hold-off: main bumps hold_trigger, the receiver counts it down
   int hold_trigger = 0;
   int hold_seen    = 0;
   int hold_left    = 0;

   unsorted_max_priority_queue #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels. Values read right after the edge are the ones the
   // edge sampled, since every driver here and in the block updates later.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            mirror.check_result(rsp_data);
         if (req_valid && !req_stall)
            mirror.take_request(req_data);
      end
   end

   // Receiver: stall at random, or hold off for a long stretch when asked.
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_TICKS;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("unsorted_max_priority_queue_test NOT OK");
      $finish;
   end

   function automatic umpq_pkg::req_type mk_req(logic op,
                                                logic signed [umpq_pkg::KEY_W-1:0] key,
                                                logic signed [umpq_pkg::VALUE_W-1:0] value);
      umpq_pkg::req_type r;
      r.op    = op;
      r.key   = key;
      r.value = value;
      return r;
   endfunction

   // Pick a random request. Keys come from several pools so that ties,
   // sign changes and the extremes all turn up often.
   function automatic umpq_pkg::req_type random_request(int insert_pct);
      umpq_pkg::req_type r;
      r.op    = ($urandom_range(99) < insert_pct) ? umpq_pkg::OP_INSERT
                                                  : umpq_pkg::OP_REMOVE;
      r.value = $urandom;
      case ($urandom_range(3))
         0: r.key = $urandom;
         1: r.key = $signed(umpq_pkg::KEY_W'($urandom_range(8))) - 4;
         2: case ($urandom_range(3))
               0: r.key = {1'b0, {(umpq_pkg::KEY_W-1){1'b1}}};
               1: r.key = {1'b1, {(umpq_pkg::KEY_W-1){1'b0}}};
               2: r.key = '0;
               default: r.key = '1;
            endcase
         default: r.key = $signed(umpq_pkg::KEY_W'($urandom_range(2000))) - 1000;
      endcase
      return r;
   endfunction

   // Offer one request and hold it until the block takes it. Idle cycles
   // go in front, so valid stays high across back-to-back transfers.
   task automatic send_request(umpq_pkg::req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait for every pending result. The wait starts with a clock
   // edge, so the last request transfer has been noted by the watcher.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.outstanding() != 0);
   endtask

   // Random traffic in bursts that lean toward insert or remove, so the
   // queue swings between empty and full many times.
   task automatic run_random(int n_items, bit with_hold);
      int burst_left;
      int insert_pct;
      burst_left = 0;
      insert_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            case ($urandom_range(2))
               0: insert_pct = 85;
               1: insert_pct = 20;
               default: insert_pct = 55;
            endcase
         end
         burst_left--;
         // stall the result side for a long stretch while requests keep coming
         if (with_hold && i == n_items / 3)
            hold_trigger <= hold_trigger + 1;
         // pause mid-phase until the block has answered everything
         if (i == (2 * n_items) / 3)
            drain_results();
         send_request(random_request(insert_pct));
      end
   endtask

   initial begin
      req_idle_pct = 35;
      rsp_idle_pct = 73;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Remove on an empty queue, with junk in the ignored fields.
      send_request(mk_req(umpq_pkg::OP_REMOVE, 32'shA5A5_5A5A, 32'sh5A5A_A5A5));

      // Fill the queue: extremes of key and value, and a few ties.
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sh0000_0000, 32'shFFFF_FFFF));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'shFFFF_FFFF, 32'sh0000_0000));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sd5, 32'sd1));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sd5, 32'sd2));
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sh7FFF_FFFF, 32'sd3));
      for (int i = 7; i < DEPTH; i++)
         send_request(mk_req(umpq_pkg::OP_INSERT, -i * 1000, i));

      // Insert into a full queue is refused.
      send_request(mk_req(umpq_pkg::OP_INSERT, 32'sd123, 32'sd456));

      // Remove the largest keys; ties must come out oldest first.
      for (int i = 0; i < 7; i++)
         send_request(mk_req(umpq_pkg::OP_REMOVE, '1, '1));

      run_random(425, 1'b0);
      drain_results();

      req_idle_pct = 73;
      rsp_idle_pct = 35;
      run_random(425, 1'b0);
      drain_results();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(425, 1'b1);

      drain_results();
      repeat (SETTLE_TICKS) @(posedge clock);

      if (mirror.mismatches == 0 && mirror.outstanding() == 0)
         $display("unsorted_max_priority_queue_test OK");
      else
         $display("unsorted_max_priority_queue_test NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/umpq_pkg.sv
hdl/umpq_mem.sv
hdl/umpq_ctrl.sv
hdl/unsorted_max_priority_queue.sv
hdl/umpq_checker.sv
tb/unsorted_max_priority_queue_test.sv
